/* hdl/adaptive_capacity_admission_fifo_macros.svh */
// Assertion macros used by the adaptive capacity admission FIFO module.
// No dependencies; included by the files that carry assertions.
`ifndef ADAPTIVE_CAPACITY_ADMISSION_FIFO_MACROS_SVH
`define ADAPTIVE_CAPACITY_ADMISSION_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ACAF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ACAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/acaf_pkg.sv */
// Package for the adaptive capacity admission FIFO: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package acaf_pkg;

   // Queue geometry.
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Field widths.
   localparam int OP_W     = 2;
   localparam int AMT_W    = 16;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 2;

   // Operation codes; bit 1 alone marks a tick.
   localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OP_W-1:0] OP_PROCESS  = 2'd1;
   localparam int              OP_TICK_BIT = 1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PROCESSED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TICK      = 3'd4;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_INIT_CAP = 2'd0;
   localparam logic [IDX_W-1:0] REG_MAX_CAP  = 2'd1;
   localparam logic [IDX_W-1:0] REG_INTERVAL = 2'd2;

   // Configuration defaults after reset.
   localparam logic [AMT_W-1:0] INIT_CAP_RESET = 16'd10;
   localparam logic [AMT_W-1:0] MAX_CAP_RESET  = 16'd40;
   localparam logic [AMT_W-1:0] INTERVAL_RESET = 16'd1;

   // One result word.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AMT_W-1:0]    processed_amount;
      logic [AMT_W-1:0]    occupancy_now;
      logic [AMT_W-1:0]    capacity_now;
   } rsp_word_type;

endpackage

/* hdl/acaf_req_if.sv */
// Request channel: one operation word per handshake.
// Depends on acaf_pkg.
`timescale 1ns / 1ps

interface acaf_req_if;
   import acaf_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [AMT_W-1:0] amount;

   modport source (output valid, output op, output amount, input ready);
   modport sink   (input valid, input op, input amount, output ready);
endinterface

/* hdl/acaf_rsp_if.sv */
// Response channel: one result word per handshake.
// Depends on acaf_pkg.
`timescale 1ns / 1ps

interface acaf_rsp_if;
   import acaf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [AMT_W-1:0]    processed_amount;
   logic [AMT_W-1:0]    occupancy_now;
   logic [AMT_W-1:0]    capacity_now;

   modport source (output valid, output status, output processed_amount,
                   output occupancy_now, output capacity_now, input ready);
   modport sink   (input valid, input status, input processed_amount,
                   input occupancy_now, input capacity_now, output ready);
endinterface

/* hdl/acaf_csr_if.sv */
// Configuration write channel: register index and write data.
// Depends on acaf_pkg.
`timescale 1ns / 1ps

interface acaf_csr_if;
   import acaf_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [AMT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/acaf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module acaf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/adaptive_capacity_admission_fifo.sv */
// Adaptive capacity admission FIFO. Add, tick and empty-queue process words go straight to the staging
// register; a process that pops an entry first waits in the pop state for the registered read of the
// amount RAM and for a free staging register. Each response passes the staging and output registers.
// A staging register feeds the output register, so one new word is taken while a response waits.
// Synchronous active-high reset loads the configuration defaults and a capacity of 10 and
// empties the queue; the amount RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module adaptive_capacity_admission_fifo (
   input logic         clock,
   input logic         reset,
   acaf_req_if.sink    req_ch,
   acaf_rsp_if.source  rsp_ch,
   acaf_csr_if.sink    csr_ch
);
   import acaf_pkg::*;
   `include "adaptive_capacity_admission_fifo_macros.svh"

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic               state_ff, state_in;
   logic [AMT_W-1:0]   init_cap_ff, max_cap_ff, interval_ff;
   logic [AMT_W-1:0]   capacity_ff, capacity_in;
   logic [AMT_W-1:0]   occupancy_ff, occupancy_in;
   logic [AMT_W-1:0]   elapsed_ff, elapsed_in;
   logic [PTR_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               stage_valid_ff, stage_valid_in;
   rsp_word_type       stage_ff, stage_in;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   logic               stage_move, stage_free, accept, csr_write;
   logic               is_tick, is_add, is_proc;
   logic               adj_due, grow, shrink, admit;
   logic [AMT_W:0]     cap_double, occ_sum;
   logic [AMT_W-1:0]   cap_adj, ram_rd_data;
   logic               ram_we;

   // Handshakes: the staging register is free when empty or moving to the output.
   assign stage_move   = stage_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign stage_free   = !stage_valid_ff || stage_move;
   assign req_ch.ready = (state_ff == ST_IDLE) && stage_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   // Operation decode; any word with bit 1 set is a tick.
   assign is_tick = req_ch.op[OP_TICK_BIT];
   assign is_add  = !is_tick && (req_ch.op == OP_ADD);
   assign is_proc = !is_tick && (req_ch.op == OP_PROCESS);

   // Capacity adjustment ahead of an add.
   assign adj_due    = elapsed_ff >= interval_ff;
   assign cap_double = {capacity_ff, 1'b0};
   assign grow       = (occupancy_ff > (capacity_ff >> 1)) && (capacity_ff < max_cap_ff);
   assign shrink     = (occupancy_ff < (capacity_ff >> 2)) && (capacity_ff > 16'd1);

   always_comb begin
      cap_adj = capacity_ff;
      if (adj_due) begin
         if (grow) begin
            cap_adj = (cap_double < {1'b0, max_cap_ff}) ? cap_double[AMT_W-1:0] : max_cap_ff;
         end else if (shrink) begin
            cap_adj = capacity_ff >> 1;
         end
      end
   end

   // Admission against the adjusted capacity and the free entries.
   assign occ_sum = {1'b0, occupancy_ff} + {1'b0, req_ch.amount};
   assign admit   = (occ_sum <= {1'b0, cap_adj}) && (count_ff < CNT_W'(FIFO_DEPTH));

   // Amount storage.
   acaf_ram #(
      .WIDTH (AMT_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (req_ch.amount),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Next-state logic for the queue, capacity and staging register.
   always_comb begin
      state_in       = state_ff;
      capacity_in    = capacity_ff;
      occupancy_in   = occupancy_ff;
      elapsed_in     = elapsed_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      stage_valid_in = stage_valid_ff && !stage_move;
      stage_in       = stage_ff;
      ram_we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_tick) begin
                  if (elapsed_ff != '1) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
                  stage_in       = '{status: STATUS_TICK, processed_amount: '0,
                                     occupancy_now: occupancy_ff, capacity_now: capacity_ff};
                  stage_valid_in = 1'b1;
               end else if (is_add) begin
                  capacity_in = cap_adj;
                  if (adj_due) begin
                     elapsed_in = '0;
                  end
                  if (admit) begin
                     ram_we       = 1'b1;
                     tail_in      = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                                    tail_ff + PTR_W'(1);
                     count_in     = count_ff + CNT_W'(1);
                     occupancy_in = occ_sum[AMT_W-1:0];
                     stage_in     = '{status: STATUS_ADDED, processed_amount: '0,
                                      occupancy_now: occ_sum[AMT_W-1:0],
                                      capacity_now: cap_adj};
                  end else begin
                     stage_in     = '{status: STATUS_DROPPED, processed_amount: '0,
                                      occupancy_now: occupancy_ff, capacity_now: cap_adj};
                  end
                  stage_valid_in = 1'b1;
               end else if (count_ff == '0) begin
                  stage_in       = '{status: STATUS_EMPTY, processed_amount: '0,
                                     occupancy_now: occupancy_ff, capacity_now: capacity_ff};
                  stage_valid_in = 1'b1;
               end else begin
                  // Head entry is being read; finish once the data returns.
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (stage_free) begin
               head_in        = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                                head_ff + PTR_W'(1);
               count_in       = count_ff - CNT_W'(1);
               occupancy_in   = occupancy_ff - ram_rd_data;
               stage_in       = '{status: STATUS_PROCESSED, processed_amount: ram_rd_data,
                                  occupancy_now: occupancy_ff - ram_rd_data,
                                  capacity_now: capacity_ff};
               stage_valid_in = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A write of the initial capacity reloads the capacity at once.
      if (csr_write && (csr_ch.index == REG_INIT_CAP)) begin
         capacity_in = (csr_ch.data == '0) ? 16'd1 : csr_ch.data;
      end
   end

   // Control and queue state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= INIT_CAP_RESET;
         occupancy_ff   <= '0;
         elapsed_ff     <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         capacity_ff    <= capacity_in;
         occupancy_ff   <= occupancy_in;
         elapsed_ff     <= elapsed_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cap_ff <= INIT_CAP_RESET;
         max_cap_ff  <= MAX_CAP_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            REG_INIT_CAP: init_cap_ff <= csr_ch.data;
            REG_MAX_CAP:  max_cap_ff  <= csr_ch.data;
            REG_INTERVAL: interval_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Staging payload.
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_word_ff <= stage_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_word_ff.status;
   assign rsp_ch.processed_amount = rsp_word_ff.processed_amount;
   assign rsp_ch.occupancy_now    = rsp_word_ff.occupancy_now;
   assign rsp_ch.capacity_now     = rsp_word_ff.capacity_now;

   // Checks on the queue bookkeeping, the capacity and the staging flow.
   `ACAF_ASSERT_IMPLY(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == tail_ff,
                      "empty queue with unequal pointers")
   `ACAF_ASSERT_NEXT(a_pop_entered, clock, reset, accept && is_proc && (count_ff != '0),
                     state_ff == ST_POP, "process did not start a read")
   `ACAF_ASSERT_IMPLY(a_pop_blocks, clock, reset, state_ff == ST_POP, !req_ch.ready,
                      "request taken during a pop")
   `ACAF_ASSERT_NEXT(a_stage_held, clock, reset, stage_valid_ff && !stage_move,
                     stage_valid_ff, "staged word lost")
   `ACAF_ASSERT_IMPLY(a_cap_nonzero, clock, reset, init_cap_ff == init_cap_ff,
                      capacity_ff != '0, "capacity reached zero")

endmodule
